@@ src/segment_box_overlap_test_defines.svh @@
// ----------------------------------------------------------------------------
// Segment box overlap test assertion macros
// Shared assertion wrappers; defining ASSERT_OFF compiles them out.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_BOX_OVERLAP_TEST_DEFINES_SVH
`define SEGMENT_BOX_OVERLAP_TEST_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked check that is switched off while reset is held.
`define SBOT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that is also evaluated during reset.
`define SBOT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define SBOT_ASSERT(lbl, prop, msg)
`define SBOT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ src/sbot_pkg.sv @@
// ----------------------------------------------------------------------------
// Segment box overlap test package
// Widths, pipeline control type and the inter-stage record of the test.
// ----------------------------------------------------------------------------
`default_nettype none

package sbot_pkg;

    // Coordinate width and the widths that follow from it.
    localparam int CW     = 32;           // coordinate, signed
    localparam int HW     = CW - 1;       // half-extent, unsigned
    localparam int DW     = CW + 1;       // end - start
    localparam int MW     = CW + 2;       // end + start - 2 * center
    localparam int SPLIT  = MW / 2;       // low slice of |M| per partial product
    localparam int MHW    = MW - SPLIT;   // high slice of |M|
    localparam int PLW    = DW + SPLIT;   // low partial product
    localparam int PHW    = DW + MHW;     // high partial product
    localparam int QW     = HW + DW;      // half-extent times |D|
    localparam int PW     = 2 * CW + 2;   // full |D| * |M| and doubled radius
    localparam int UW     = PW + 2;       // signed cross-axis distance
    localparam int NAXES  = 3;
    localparam int STAGES = 6;

    // One advance enable per pipeline stage, stage 1 at bit 0.
    typedef logic [STAGES-1:0] t_stage_en;

    // Result of the front end, handed to the cross-axis units.
    typedef struct packed {
        logic [NAXES-1:0][DW-1:0] mag_d;
        logic [NAXES-1:0][MW-1:0] mag_m;
        logic [NAXES-1:0]         neg_d;
        logic [NAXES-1:0]         neg_m;
        logic [NAXES-1:0][HW-1:0] half;
        logic                     box_miss;
    } t_prep_out;

endpackage

`default_nettype wire

@@ src/sbot_prep.sv @@
// ----------------------------------------------------------------------------
// Segment box overlap test front end
// Stages 1 and 2: doubled direction and midpoint offset, magnitudes, box axes.
// ----------------------------------------------------------------------------
`default_nettype none

module sbot_prep (
    input  wire logic                                        i_clk,
    input  wire sbot_pkg::t_stage_en                         i_en,
    input  wire logic [sbot_pkg::NAXES-1:0][sbot_pkg::CW-1:0] i_start,
    input  wire logic [sbot_pkg::NAXES-1:0][sbot_pkg::CW-1:0] i_end_pt,
    input  wire logic [sbot_pkg::NAXES-1:0][sbot_pkg::CW-1:0] i_center,
    input  wire logic [sbot_pkg::NAXES-1:0][sbot_pkg::HW-1:0] i_half,
    output sbot_pkg::t_prep_out                              o_prep
);
    import sbot_pkg::*;

    logic signed [DW-1:0] r_d [NAXES];
    logic signed [DW-1:0] n_d [NAXES];
    logic signed [MW-1:0] r_m [NAXES];
    logic signed [MW-1:0] n_m [NAXES];
    logic [NAXES-1:0][HW-1:0] r_half;
    t_prep_out r_out;
    t_prep_out n_out;

    // Stage 1: D = end - start and M = end + start - 2 * center, exact widths.
    always_comb begin
        for (int a = 0; a < NAXES; a++) begin
            n_d[a] = DW'(signed'(i_end_pt[a])) - DW'(signed'(i_start[a]));
            n_m[a] = MW'(signed'(i_end_pt[a])) + MW'(signed'(i_start[a]))
                   - (MW'(signed'(i_center[a])) <<< 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int a = 0; a < NAXES; a++) begin
                r_d[a] <= n_d[a];
                r_m[a] <= n_m[a];
            end
            r_half <= i_half;
        end
    end

    // Stage 2: magnitudes and signs; a box axis misses when |M| > 2h + |D|.
    always_comb begin
        logic [MW-1:0] lim;
        n_out.box_miss = 1'b0;
        for (int a = 0; a < NAXES; a++) begin
            n_out.neg_d[a] = r_d[a][DW-1];
            n_out.neg_m[a] = r_m[a][MW-1];
            n_out.mag_d[a] = r_d[a][DW-1] ? DW'(-r_d[a]) : DW'(r_d[a]);
            n_out.mag_m[a] = r_m[a][MW-1] ? MW'(-r_m[a]) : MW'(r_m[a]);
            n_out.half[a]  = r_half[a];
            lim = MW'({r_half[a], 1'b0}) + MW'(n_out.mag_d[a]);
            if (n_out.mag_m[a] > lim) begin
                n_out.box_miss = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_out <= n_out;
        end
    end

    assign o_prep = r_out;

endmodule

`default_nettype wire

@@ src/sbot_cross_axis.sv @@
// ----------------------------------------------------------------------------
// Segment box overlap test cross-product axis
// Stages 3 to 5: one cross axis, |Da*Mb - Db*Ma| > 2(ha|Db| + hb|Da|).
// ----------------------------------------------------------------------------
`default_nettype none

module sbot_cross_axis (
    input  wire logic                    i_clk,
    input  wire sbot_pkg::t_stage_en     i_en,
    input  wire logic [sbot_pkg::DW-1:0] i_mag_da,
    input  wire logic [sbot_pkg::DW-1:0] i_mag_db,
    input  wire logic [sbot_pkg::MW-1:0] i_mag_ma,
    input  wire logic [sbot_pkg::MW-1:0] i_mag_mb,
    input  wire logic                    i_neg_da,
    input  wire logic                    i_neg_db,
    input  wire logic                    i_neg_ma,
    input  wire logic                    i_neg_mb,
    input  wire logic [sbot_pkg::HW-1:0] i_half_a,
    input  wire logic [sbot_pkg::HW-1:0] i_half_b,
    output logic                         o_sep
);
    import sbot_pkg::*;

    // Stage 3 registers: partial products.
    logic [PLW-1:0] r_p1_lo;
    logic [PHW-1:0] r_p1_hi;
    logic [PLW-1:0] r_p2_lo;
    logic [PHW-1:0] r_p2_hi;
    logic [QW-1:0]  r_q1;
    logic [QW-1:0]  r_q2;
    logic           r_same3;
    // Stage 4 registers: whole products and the doubled radius.
    logic [PW-1:0]  r_p1;
    logic [PW-1:0]  r_p2;
    logic [PW-1:0]  r_rhs4;
    logic           r_same4;
    // Stage 5 registers: signed distance along the axis.
    logic signed [UW-1:0] r_u;
    logic [PW-1:0]        r_rhs5;
    logic signed [UW-1:0] n_u;
    logic signed [UW-1:0] rhs_s;

    // Stage 3: |M| is split in two slices so each multiplier stays narrow.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_p1_lo <= PLW'(i_mag_da) * PLW'(i_mag_mb[SPLIT-1:0]);
            r_p1_hi <= PHW'(i_mag_da) * PHW'(i_mag_mb[MW-1:SPLIT]);
            r_p2_lo <= PLW'(i_mag_db) * PLW'(i_mag_ma[SPLIT-1:0]);
            r_p2_hi <= PHW'(i_mag_db) * PHW'(i_mag_ma[MW-1:SPLIT]);
            r_q1    <= QW'(i_half_a) * QW'(i_mag_db);
            r_q2    <= QW'(i_half_b) * QW'(i_mag_da);
            // Both products carry the same sign: the distance is a difference.
            r_same3 <= (i_neg_da ^ i_neg_mb) == (i_neg_db ^ i_neg_ma);
        end
    end

    // Stage 4: recombine the slices and form the doubled radius.
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_p1    <= PW'({r_p1_hi, {SPLIT{1'b0}}}) + PW'(r_p1_lo);
            r_p2    <= PW'({r_p2_hi, {SPLIT{1'b0}}}) + PW'(r_p2_lo);
            r_rhs4  <= PW'({(QW + 1)'(r_q1) + (QW + 1)'(r_q2), 1'b0});
            r_same4 <= r_same3;
        end
    end

    // Stage 5: the distance up to its sign, which the compare ignores.
    assign n_u = r_same4 ? signed'(UW'(r_p1) - UW'(r_p2))
                         : signed'(UW'(r_p1) + UW'(r_p2));

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_u    <= n_u;
            r_rhs5 <= r_rhs4;
        end
    end

    // Separated when the distance lies strictly outside the radius.
    assign rhs_s = signed'(UW'(r_rhs5));
    assign o_sep = (r_u > rhs_s) || (r_u < -rhs_s);

endmodule

`default_nettype wire

@@ src/segment_box_overlap_test.sv @@
// ----------------------------------------------------------------------------
// Segment box overlap test
// Separating axis test of a line segment against an axis-aligned box.
// ----------------------------------------------------------------------------
// The block takes one segment and box per cycle while o_ready is high and
// returns one overlap bit per item, in the order the items were accepted.
// It is a six-stage pipeline: the doubled direction and
// midpoint offset, their magnitudes with the three box-axis tests, a bank of
// eighteen partial-product multipliers, product recombination, the signed
// cross-axis distance, and the output register that holds the result. Every
// stage holds its item on its own when the next one cannot advance, so bubbles
// are squeezed out during an output stall. Touching counts as overlap.
`default_nettype none

`include "segment_box_overlap_test_defines.svh"

module segment_box_overlap_test (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [sbot_pkg::CW-1:0] i_start_x,
    input  wire logic [sbot_pkg::CW-1:0] i_start_y,
    input  wire logic [sbot_pkg::CW-1:0] i_start_z,
    input  wire logic [sbot_pkg::CW-1:0] i_end_x,
    input  wire logic [sbot_pkg::CW-1:0] i_end_y,
    input  wire logic [sbot_pkg::CW-1:0] i_end_z,
    input  wire logic [sbot_pkg::CW-1:0] i_center_x,
    input  wire logic [sbot_pkg::CW-1:0] i_center_y,
    input  wire logic [sbot_pkg::CW-1:0] i_center_z,
    input  wire logic [sbot_pkg::HW-1:0] i_half_x,
    input  wire logic [sbot_pkg::HW-1:0] i_half_y,
    input  wire logic [sbot_pkg::HW-1:0] i_half_z,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic                         o_overlap
);
    import sbot_pkg::*;

    t_stage_en              r_valid;
    t_stage_en              en;
    t_prep_out              prep;
    logic [NAXES-1:0]       sep;
    logic                   r_miss3;
    logic                   r_miss4;
    logic                   r_miss5;
    logic                   r_overlap;

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        en[STAGES-1] = !r_valid[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_valid[STAGES-1];

    // Valid bits travel with their item through the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // Front end: stages 1 and 2.
    sbot_prep u_prep (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_start  ({i_start_z, i_start_y, i_start_x}),
        .i_end_pt ({i_end_z, i_end_y, i_end_x}),
        .i_center ({i_center_z, i_center_y, i_center_x}),
        .i_half   ({i_half_z, i_half_y, i_half_x}),
        .o_prep   (prep)
    );

    // Cross axes: stages 3 to 5, one unit per axis, pairs taken cyclically.
    for (genvar g = 0; g < NAXES; g++) begin : g_cross
        localparam int A = (g + 1) % NAXES;
        localparam int B = (g + 2) % NAXES;
        sbot_cross_axis u_cross (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_mag_da (prep.mag_d[A]),
            .i_mag_db (prep.mag_d[B]),
            .i_mag_ma (prep.mag_m[A]),
            .i_mag_mb (prep.mag_m[B]),
            .i_neg_da (prep.neg_d[A]),
            .i_neg_db (prep.neg_d[B]),
            .i_neg_ma (prep.neg_m[A]),
            .i_neg_mb (prep.neg_m[B]),
            .i_half_a (prep.half[A]),
            .i_half_b (prep.half[B]),
            .o_sep    (sep[g])
        );
    end

    // The box-axis verdict rides alongside the cross-axis stages.
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_miss3 <= prep.box_miss;
        end
        if (en[3]) begin
            r_miss4 <= r_miss3;
        end
        if (en[4]) begin
            r_miss5 <= r_miss4;
        end
    end

    // Stage 6: output register; any separating axis means no overlap.
    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_overlap <= !(r_miss5 || (|sep));
        end
    end

    assign o_overlap = r_overlap;

    `SBOT_ASSERT(a_ready_when_drained, (!o_valid || i_ready) |-> o_ready, "input stalled while the output can drain")
    `SBOT_ASSERT(a_accept_lands, (i_valid && o_ready) |=> r_valid[0], "accepted item missing from stage one")
    `SBOT_ASSERT(a_stage_holds, (r_valid[2] && !en[2]) |=> r_valid[2], "stalled item lost in stage three")
    `SBOT_ASSERT(a_box_miss_wins, (r_valid[4] && r_miss5 && en[5]) |=> !o_overlap, "box-axis miss reported as overlap")
    `SBOT_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "output valid right after reset")

endmodule

`default_nettype wire

@@ verif/segment_box_overlap_test_test.sv @@
// ----------------------------------------------------------------------------
// Segment box overlap test testbench
// Drives segment and box items through the valid/ready input, predicts each
// overlap bit with an exact wide-integer separating axis check, and compares
// every returned result against the oldest pending prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_box_overlap_test_test;

    import sbot_pkg::CW;
    import sbot_pkg::HW;

    // One Q16.16 unit.
    localparam int ONE = 32'h0001_0000;

    // One segment and box item. Index 0 is x, 1 is y and 2 is z.
    typedef struct packed {
        logic [2:0][CW-1:0] seg_start;
        logic [2:0][CW-1:0] seg_stop;
        logic [2:0][CW-1:0] center;
        logic [2:0][HW-1:0] half;
    } t_seg_box;

    typedef logic signed [127:0] t_wide;

    logic          i_clk      = 1'b0;
    logic          i_rst_n    = 1'b0;
    logic          i_valid    = 1'b0;
    logic          i_ready    = 1'b0;
    logic [CW-1:0] i_start_x  = '0;
    logic [CW-1:0] i_start_y  = '0;
    logic [CW-1:0] i_start_z  = '0;
    logic [CW-1:0] i_end_x    = '0;
    logic [CW-1:0] i_end_y    = '0;
    logic [CW-1:0] i_end_z    = '0;
    logic [CW-1:0] i_center_x = '0;
    logic [CW-1:0] i_center_y = '0;
    logic [CW-1:0] i_center_z = '0;
    logic [HW-1:0] i_half_x   = '0;
    logic [HW-1:0] i_half_y   = '0;
    logic [HW-1:0] i_half_z   = '0;
    logic          o_ready;
    logic          o_valid;
    logic          o_overlap;

    // Expected overlap bits, oldest first.
    bit overlap_expected_q[$];

    int items_sent      = 0;
    int results_checked = 0;
    int mismatch_count  = 0;

    // Idle bounds for each side, and a one-shot long output hold request.
    int tx_gap_max   = 12;
    int rx_stall_max = 12;
    int ready_hold   = 0;

    segment_box_overlap_test dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_start_x  (i_start_x),
        .i_start_y  (i_start_y),
        .i_start_z  (i_start_z),
        .i_end_x    (i_end_x),
        .i_end_y    (i_end_y),
        .i_end_z    (i_end_z),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_center_z (i_center_z),
        .i_half_x   (i_half_x),
        .i_half_y   (i_half_y),
        .i_half_z   (i_half_z),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_overlap  (o_overlap)
    );

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Give up if the run hangs.
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Overlap predictor
    // ------------------------------------------------------------------------

    function automatic t_wide mag128(input t_wide v);
        return (v < 0) ? -v : v;
    endfunction

    // Twice the direction and twice the midpoint offset keep every test exact.
    function automatic bit predict_overlap(input t_seg_box it);
        t_wide d[3];
        t_wide m[3];
        t_wide ad[3];
        t_wide h[3];
        t_wide p0;
        t_wide p1;
        t_wide ce;
        t_wide sep_dist;
        t_wide radius;
        bit    hit;
        int    a;
        int    b;
        hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
            p0    = $signed(it.seg_start[i]);
            p1    = $signed(it.seg_stop[i]);
            ce    = $signed(it.center[i]);
            h[i]  = it.half[i];
            d[i]  = p1 - p0;
            m[i]  = p1 + p0 - 2 * ce;
            ad[i] = mag128(d[i]);
            // Box axis: strict excess separates.
            if (mag128(m[i]) > 2 * h[i] + ad[i])
                hit = 1'b0;
        end
        // Cross axes: the edge direction crossed with each box axis.
        for (int i = 0; i < 3; i++) begin
            a        = (i + 1) % 3;
            b        = (i + 2) % 3;
            sep_dist = mag128(d[a] * m[b] - d[b] * m[a]);
            radius   = 2 * (h[a] * ad[b] + h[b] * ad[a]);
            if (sep_dist > radius)
                hit = 1'b0;
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------------
    // Item construction
    // ------------------------------------------------------------------------

    function automatic t_seg_box make_item(input int sx, input int sy, input int sz,
                                           input int ex, input int ey, input int ez,
                                           input int cx, input int cy, input int cz,
                                           input int hx, input int hy, input int hz);
        t_seg_box it;
        it.seg_start = {CW'(sz), CW'(sy), CW'(sx)};
        it.seg_stop  = {CW'(ez), CW'(ey), CW'(ex)};
        it.center    = {CW'(cz), CW'(cy), CW'(cx)};
        it.half      = {HW'(hz), HW'(hy), HW'(hx)};
        return it;
    endfunction

    // Uniform signed offset in [-2^(k+1), 2^(k+1)], k at most 29.
    function automatic logic [CW-1:0] rand_offset(input int k);
        longint span;
        span = longint'(1) << (k + 1);
        return CW'(longint'($urandom_range(0, 32'(2 * span))) - span);
    endfunction

    // Mostly geometry near the box so that every axis decides some items.
    function automatic t_seg_box rand_item();
        t_seg_box    it;
        int          kind;
        int          k;
        int          ax;
        logic [31:0] hmask;
        longint      push;
        kind  = $urandom_range(0, 9);
        k     = $urandom_range(0, 29);
        hmask = (32'd1 << k) - 32'd1;
        case (kind)
            0, 1: begin
                // Raw bit patterns over the full field ranges.
                for (int i = 0; i < 3; i++) begin
                    it.seg_start[i] = $urandom;
                    it.seg_stop[i]  = $urandom;
                    it.center[i]    = $urandom;
                    it.half[i]      = HW'($urandom);
                end
            end
            8: begin
                // One end sits on a face, the other leaves outward.
                for (int i = 0; i < 3; i++) begin
                    it.center[i]    = rand_offset(29);
                    it.half[i]      = HW'($urandom & hmask);
                    it.seg_start[i] = it.center[i] + CW'(longint'($urandom_range(0,
                                      32'(2 * it.half[i]))) - longint'(it.half[i]));
                end
                ax   = $urandom_range(0, 2);
                push = longint'($urandom_range(0, 32'(hmask) + 1));
                if ($urandom_range(0, 1)) begin
                    it.seg_start[ax] = it.center[ax] + CW'(it.half[ax]);
                end else begin
                    it.seg_start[ax] = it.center[ax] - CW'(it.half[ax]);
                    push             = -push;
                end
                it.seg_stop     = it.seg_start;
                it.seg_stop[ax] = it.seg_start[ax] + CW'(push);
                if ($urandom_range(0, 1))
                    {it.seg_start, it.seg_stop} = {it.seg_stop, it.seg_start};
            end
            9: begin
                // Small magnitudes around the origin.
                for (int i = 0; i < 3; i++) begin
                    it.seg_start[i] = rand_offset(k % 16);
                    it.seg_stop[i]  = rand_offset(k % 16);
                    it.center[i]    = rand_offset(k % 16);
                    it.half[i]      = HW'($urandom_range(0, 32'h1_0000));
                end
            end
            default: begin
                // Segment ends scattered around a box of matching scale.
                for (int i = 0; i < 3; i++) begin
                    it.center[i]    = $urandom;
                    it.half[i]      = ($urandom_range(0, 7) == 0) ? '0 : HW'($urandom & hmask);
                    it.seg_start[i] = it.center[i] + rand_offset(k);
                    it.seg_stop[i]  = it.center[i] + rand_offset(k);
                end
                // A degenerate segment is a point-in-box test.
                if (kind == 7)
                    it.seg_stop = it.seg_start;
            end
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one item after a random gap and hold it until it is taken.
    task automatic send_item(input t_seg_box it);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start_x  = it.seg_start[0];
        i_start_y  = it.seg_start[1];
        i_start_z  = it.seg_start[2];
        i_end_x    = it.seg_stop[0];
        i_end_y    = it.seg_stop[1];
        i_end_z    = it.seg_stop[2];
        i_center_x = it.center[0];
        i_center_y = it.center[1];
        i_center_z = it.center[2];
        i_half_x   = it.half[0];
        i_half_y   = it.half[1];
        i_half_z   = it.half[2];
        i_valid    = 1'b1;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        overlap_expected_q.push_back(predict_overlap(it));
        items_sent++;
    endtask

    // Stop offering and wait for every pending result.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (overlap_expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    // Stall before each result for a random count or a requested long hold.
    initial begin : result_receiver
        int stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (ready_hold != 0) begin
                stall      = ready_hold;
                ready_hold = 0;
            end else begin
                stall = $urandom_range(0, rx_stall_max);
            end
            if (stall > 0) begin
                i_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50)
            $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && o_valid && i_ready) begin
            if (overlap_expected_q.size() == 0) begin
                report_mismatch("overlap result arrived with no item pending");
            end else begin
                want = overlap_expected_q.pop_front();
                if (o_overlap !== want)
                    report_mismatch($sformatf("result %0d: overlap %b, expected %b",
                                              results_checked, o_overlap, want));
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, touching contact, degenerate segments and cross axes.
    task automatic test_directed();
        tx_gap_max   = 12;
        rx_stall_max = 12;
        send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
        send_item(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0));
        // Far corner of the largest box, touching.
        send_item(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        // Degenerate segments: inside, on a face, just outside, on a corner, far.
        send_item(make_item(ONE/2, ONE/2, ONE/2, ONE/2, ONE/2, ONE/2, 0, 0, 0, ONE, ONE, ONE));
        send_item(make_item(ONE, 0, 0, ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE));
        send_item(make_item(ONE + 1, 0, 0, ONE + 1, 0, 0, 0, 0, 0, ONE, ONE, ONE));
        send_item(make_item(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE));
        send_item(make_item(5*ONE, 5*ONE, 5*ONE, 5*ONE, 5*ONE, 5*ONE, 0, 0, 0, ONE, ONE, ONE));
        // Segment lying in a face plane, and one just past it.
        send_item(make_item(ONE, -2*ONE, 0, ONE, 2*ONE, 0, 0, 0, 0, ONE, ONE, ONE));
        send_item(make_item(ONE + 1, -2*ONE, 0, ONE + 1, 2*ONE, 0, 0, 0, 0, ONE, ONE, ONE));
        // Straight through, and entirely to one side.
        send_item(make_item(-3*ONE, 0, 0, 3*ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE));
        send_item(make_item(2*ONE, 0, 0, 5*ONE, 0, 0, 0, 0, 0, ONE, ONE, ONE));
        // Diagonal past an edge: touching, then separated only by a cross axis.
        send_item(make_item(2*ONE, 0, 0, 0, 2*ONE, 0, 0, 0, 0, ONE, ONE, ONE));
        send_item(make_item(5*ONE/2, 0, 0, 0, 5*ONE/2, 0, 0, 0, 0, ONE, ONE, ONE));
        send_item(make_item(0, 5*ONE/2, 0, 0, 0, 5*ONE/2, 0, 0, 0, ONE, ONE, ONE));
        send_item(make_item(0, 0, 5*ONE/2, 5*ONE/2, 0, 0, 0, 0, 0, ONE, ONE, ONE));
        // A zero-size box on the segment's path.
        send_item(make_item(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, 0, 0, 0, 0));
        // Negative coordinates.
        send_item(make_item(-11*ONE, -20*ONE, -10*ONE, -11*ONE, 0, -10*ONE,
                            -10*ONE, -10*ONE, -10*ONE, 2*ONE, 2*ONE, 2*ONE));
        // Alternating bit patterns.
        send_item(make_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'h2AAA_AAAA, 32'h5555_5555, 32'h2AAA_AAAA));
        wait_drained();
    endtask

    // Random geometry with random idling on both sides.
    task automatic test_random_idle(input int count);
        tx_gap_max   = 12;
        rx_stall_max = 12;
        repeat (count) send_item(rand_item());
        wait_drained();
    endtask

    // Random geometry at full rate on both sides.
    task automatic test_streaming(input int count);
        tx_gap_max   = 0;
        rx_stall_max = 0;
        repeat (count) send_item(rand_item());
        wait_drained();
    endtask

    // Hold the output off while the input keeps streaming, so the pipeline fills.
    task automatic test_output_backpressure(input int hold, input int count);
        tx_gap_max   = 0;
        rx_stall_max = 0;
        ready_hold   = hold;
        repeat (count) send_item(rand_item());
        wait_drained();
    endtask

    // Bursts that switch idling on and off independently per side.
    task automatic test_mixed_bursts(input int bursts);
        for (int n = 0; n < bursts; n++) begin
            tx_gap_max   = $urandom_range(0, 1) ? 12 : 0;
            rx_stall_max = $urandom_range(0, 1) ? 12 : 0;
            repeat (20) send_item(rand_item());
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        int drain_cycles;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_idle(600);
        test_output_backpressure(60, 50);
        test_streaming(350);
        test_output_backpressure(40, 50);
        test_mixed_bursts(20);

        // Let the pipeline settle and catch any stray result.
        drain_cycles = 0;
        while (overlap_expected_q.size() != 0 && drain_cycles < 2000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (overlap_expected_q.size() != 0)
            report_mismatch($sformatf("%0d overlap results never arrived",
                                      overlap_expected_q.size()));

        $display("Checked %0d overlap results for %0d segment/box items: extremes,",
                 results_checked, items_sent);
        $display("touching, degenerate, cross-axis and random geometry under stalls.");
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
